@@ sv/bev_pkg.sv @@
`timescale 1ns / 1ps
// Package for the button event generator.
// Holds the controller states, event codes, register indexes and the command/status structs.
package bev_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_KEY,
        S_REL,
        S_FLUSH
    } t_state;

    typedef enum logic [2:0] {
        EV_PRESS   = 3'd0,
        EV_RELEASE = 3'd1,
        EV_SHORT   = 3'd2,
        EV_LONG    = 3'd3,
        EV_REPEAT  = 3'd4
    } t_event_type;

    localparam logic [1:0] CFG_DEBOUNCE_TICKS   = 2'd0;
    localparam logic [1:0] CFG_PRESS_PERIOD     = 2'd1;
    localparam logic [1:0] CFG_LONG_PRESS_COUNT = 2'd2;
    localparam logic [1:0] CFG_INVERT_MASK      = 2'd3;

    localparam logic [7:0]  RST_DEBOUNCE_TICKS   = 8'd30;
    localparam logic [15:0] RST_PRESS_PERIOD     = 16'd150;
    localparam logic [7:0]  RST_LONG_PRESS_COUNT = 8'd2;
    localparam logic [5:0]  RST_INVERT_MASK      = 6'd0;
    localparam logic [7:0]  RST_DEBOUNCE_COUNT   = 8'd15;

    localparam int PIN_W = 6;

    typedef struct packed {
        logic accept;
        logic step;
        logic release_ev;
        logic flush;
    } t_dp_cmd;

    typedef struct packed {
        logic can_push;
        logic step_short;
        logic last_key;
        logic pend_valid;
        logic out_free;
    } t_dp_stat;

endpackage

@@ sv/button_event_generator.sv @@
`timescale 1ns / 1ps
// Button event generator: debounce, press, release, short, long and repeat events for each key.
// Each event is held in a pending register until the next event or the end-of-tick flush, so the
// last flag can be set; it then moves to the output register.
// A new tick is taken only after all keys are walked by the single shared per-key update; a key that
// ends a short press takes an extra step for its release event; output stalls hold the walk.
// Reset is synchronous and active low: all keys released, debounce counts at 15, registers at defaults.
module button_event_generator #(
    parameter int NUM_KEYS = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [5:0]  i_pin_levels,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_event_key,
    output logic [2:0]  o_event_type,
    output logic [31:0] o_press_sequence,
    output logic        o_last
);
    import bev_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    bev_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bev_datapath #(
        .NUM_KEYS (NUM_KEYS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_pin_levels     (i_pin_levels),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_event_key      (o_event_key),
        .o_event_type     (o_event_type),
        .o_press_sequence (o_press_sequence),
        .o_last           (o_last)
    );

endmodule

@@ sv/bev_ctrl.sv @@
`timescale 1ns / 1ps
// Controller of the button event generator: walks the keys of one tick.
// Depends on bev_pkg for states and the command/status structs.
module bev_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  bev_pkg::t_dp_stat i_stat,
    output bev_pkg::t_dp_cmd  o_cmd
);
    import bev_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_KEY;
                end
            end
            S_KEY: begin
                if (i_stat.can_push) begin
                    priority if (i_stat.step_short) begin
                        n_state = S_REL;
                    end else if (i_stat.last_key) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_REL: begin
                if (i_stat.can_push) begin
                    n_state = i_stat.last_key ? S_FLUSH : S_KEY;
                end
            end
            S_FLUSH: begin
                if (!i_stat.pend_valid || i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            S_KEY:   o_cmd.step       = i_stat.can_push;
            S_REL:   o_cmd.release_ev = i_stat.can_push;
            S_FLUSH: o_cmd.flush      = i_stat.pend_valid && i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

@@ sv/bev_datapath.sv @@
`timescale 1ns / 1ps
// Datapath of the button event generator: configuration, per-key state and event output.
// Depends on bev_pkg for event codes, register indexes and the command/status structs.
module bev_datapath #(
    parameter int NUM_KEYS = 6
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  bev_pkg::t_dp_cmd         i_cmd,
    output bev_pkg::t_dp_stat        o_stat,
    input  logic [bev_pkg::PIN_W-1:0] i_pin_levels,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_index,
    input  logic [15:0]              i_cfg_data,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [2:0]               o_event_key,
    output logic [2:0]               o_event_type,
    output logic [31:0]              o_press_sequence,
    output logic                     o_last
);
    import bev_pkg::*;

    localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    logic [7:0]  r_debounce_ticks;
    logic [15:0] r_press_period;
    logic [7:0]  r_long_press_count;
    logic [5:0]  r_invert_mask;

    logic [PIN_W-1:0] r_levels;
    logic [KEY_W-1:0] r_idx;
    logic [31:0]      r_gseq;

    logic        r_stable  [NUM_KEYS];
    logic [7:0]  r_dbc     [NUM_KEYS];
    logic [7:0]  r_hold    [NUM_KEYS];
    logic [15:0] r_period  [NUM_KEYS];
    logic        r_running [NUM_KEYS];
    logic [31:0] r_kseq    [NUM_KEYS];

    logic              r_pend_valid;
    logic [2:0]        r_pend_key;
    t_event_type       r_pend_type;
    logic [31:0]       r_pend_seq;

    logic              r_out_valid;
    logic [2:0]        r_out_key;
    t_event_type       r_out_type;
    logic [31:0]       r_out_seq;
    logic              r_out_last;

    logic [NUM_KEYS-1:0] lvl_vec;
    logic [7:0]  full;
    logic [7:0]  c0;
    logic [7:0]  c1;
    logic        ev_press;
    logic        ev_rel;
    logic        ev_short;
    logic        tmr_active;
    logic [16:0] tick_next;
    logic        fire;
    logic [8:0]  fire_next;
    logic        out_free;
    logic        push;
    t_event_type push_type;
    logic [31:0] push_seq;
    logic [31:0] gseq_next;

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lvl
        if (k < PIN_W) begin : g_pin
            assign lvl_vec[k] = r_levels[k];
        end else begin : g_none
            assign lvl_vec[k] = 1'b0;
        end
    end

    assign full = (r_debounce_ticks == 8'd0) ? 8'd1 : r_debounce_ticks;
    assign c0   = (r_dbc[r_idx] > full) ? full : r_dbc[r_idx];

    always_comb begin
        if (lvl_vec[r_idx]) begin
            c1 = (c0 < full) ? c0 + 8'd1 : c0;
        end else begin
            c1 = (c0 > 8'd0) ? c0 - 8'd1 : c0;
        end
    end

    assign ev_press   = (c1 == full) && !r_stable[r_idx];
    assign ev_rel     = !ev_press && (c1 == 8'd0) && r_stable[r_idx];
    assign ev_short   = ev_rel && (r_hold[r_idx] < r_long_press_count);
    assign tmr_active = !ev_press && !ev_rel && r_running[r_idx];
    assign tick_next  = {1'b0, r_period[r_idx]} + 17'd1;
    assign fire       = tick_next >= {1'b0, r_press_period};
    assign fire_next  = {1'b0, r_hold[r_idx]} + 9'd1;
    assign gseq_next  = r_gseq + 32'd1;

    always_comb begin
        push      = 1'b0;
        push_type = EV_PRESS;
        push_seq  = r_kseq[r_idx];
        if (i_cmd.release_ev) begin
            push      = 1'b1;
            push_type = EV_RELEASE;
        end else if (i_cmd.step) begin
            priority if (ev_press) begin
                push     = 1'b1;
                push_seq = gseq_next;
            end else if (ev_rel) begin
                push      = 1'b1;
                push_type = ev_short ? EV_SHORT : EV_RELEASE;
            end else if (tmr_active && fire) begin
                if (fire_next == {1'b0, r_long_press_count}) begin
                    push      = 1'b1;
                    push_type = EV_LONG;
                end else if (fire_next > {1'b0, r_long_press_count}) begin
                    push      = 1'b1;
                    push_type = EV_REPEAT;
                end
            end
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    assign o_stat.can_push   = !r_pend_valid || out_free;
    assign o_stat.step_short = ev_short;
    assign o_stat.last_key   = (r_idx == KEY_W'(NUM_KEYS - 1));
    assign o_stat.pend_valid = r_pend_valid;
    assign o_stat.out_free   = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks   <= RST_DEBOUNCE_TICKS;
            r_press_period     <= RST_PRESS_PERIOD;
            r_long_press_count <= RST_LONG_PRESS_COUNT;
            r_invert_mask      <= RST_INVERT_MASK;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEBOUNCE_TICKS:   r_debounce_ticks   <= i_cfg_data[7:0];
                CFG_PRESS_PERIOD:     r_press_period     <= i_cfg_data;
                CFG_LONG_PRESS_COUNT: r_long_press_count <= i_cfg_data[7:0];
                CFG_INVERT_MASK:      r_invert_mask      <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_gseq  <= '0;
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_stable[k]  <= 1'b0;
                r_dbc[k]     <= RST_DEBOUNCE_COUNT;
                r_hold[k]    <= '0;
                r_period[k]  <= '0;
                r_running[k] <= 1'b0;
                r_kseq[k]    <= '0;
            end
        end else begin
            if (i_cmd.accept) begin
                r_idx <= '0;
            end else if (i_cmd.release_ev || (i_cmd.step && !ev_short)) begin
                r_idx <= r_idx + KEY_W'(1);
            end
            if (i_cmd.step) begin
                r_dbc[r_idx] <= c1;
                priority if (ev_press) begin
                    r_stable[r_idx]  <= 1'b1;
                    r_gseq           <= gseq_next;
                    r_kseq[r_idx]    <= gseq_next;
                    r_running[r_idx] <= 1'b1;
                    r_period[r_idx]  <= '0;
                end else if (ev_rel) begin
                    r_stable[r_idx]  <= 1'b0;
                    r_running[r_idx] <= 1'b0;
                    r_period[r_idx]  <= '0;
                    r_hold[r_idx]    <= '0;
                end else if (tmr_active) begin
                    if (fire) begin
                        r_period[r_idx] <= '0;
                        if (fire_next <= {1'b0, r_long_press_count}) begin
                            r_hold[r_idx] <= fire_next[7:0];
                        end
                    end else begin
                        r_period[r_idx] <= tick_next[15:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_levels <= i_pin_levels ^ r_invert_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (push) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end
            if ((push && r_pend_valid) || i_cmd.flush) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_pend_key  <= 3'(r_idx);
            r_pend_type <= push_type;
            r_pend_seq  <= push_seq;
        end
        if ((push && r_pend_valid) || i_cmd.flush) begin
            r_out_key  <= r_pend_key;
            r_out_type <= r_pend_type;
            r_out_seq  <= r_pend_seq;
            r_out_last <= i_cmd.flush;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_event_key      = r_out_key;
    assign o_event_type     = r_out_type;
    assign o_press_sequence = r_out_seq;
    assign o_last           = r_out_last;

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && r_pend_valid) |-> out_free)
        else $error("Event pushed while the output register was full.");
    a_flush_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |-> (r_pend_valid && !push))
        else $error("Flush without a pending event.");
    a_accept_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept |-> !r_pend_valid)
        else $error("New tick accepted with an event still pending.");

endmodule
